// ===== hw/rtl/rtsr_pkg.sv =====
`timescale 1ns / 1ps

package rtsr_pkg;

   // Number of time bytes held for readout
   localparam int TIME_BYTES = 7;

   // Default depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Line event opcodes
   localparam logic [2:0] OP_ENABLE    = 3'd0;
   localparam logic [2:0] OP_CLOCK     = 3'd1;
   localparam logic [2:0] OP_DIRECTION = 3'd2;
   localparam logic [2:0] OP_DATA_IN   = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;
   localparam logic [2:0] OP_TIME      = 3'd5;

   // Byte index saturates here; this index reads as zero
   localparam logic [2:0] BYTE_INDEX_MAX = 3'd7;

   // Bit counter value that forces a byte load on the next clock rise
   localparam logic [3:0] BIT_COUNT_RELOAD = 4'd8;

   // Sunday (and out-of-range seven) map to code 7
   localparam logic [2:0] WEEKDAY_CODE [8] = '{3'd7, 3'd1, 3'd2, 3'd3,
                                              3'd4, 3'd5, 3'd6, 3'd7};

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ENABLE,
      CMD_CLOCK,
      CMD_DATA_IN,
      CMD_TIME
   } rtsr_kind_type;

   // One classified command as queued between front and back
   typedef struct packed {
      rtsr_kind_type kind;
      logic          level;
      logic [7:0]    sec_bcd;
      logic [7:0]    min_bcd;
      logic [7:0]    hour_bcd;
      logic [7:0]    day_bcd;
      logic [7:0]    mon_bcd;
      logic [2:0]    wd_code;
      logic [6:0]    year_rem;   // year modulo 100
   } rtsr_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rtsr_qstat_type;

   // Two-digit BCD of a value below 128; tens by reciprocal of ten
   function automatic logic [7:0] bcd_of(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      prod  = 15'(v) * 15'd205;
      tens  = prod[14:11];
      units = v - 7'(tens * 4'd10);
      return {tens, units[3:0]};
   endfunction

endpackage

// ===== hw/rtl/rtsr_front.sv =====
`timescale 1ns / 1ps

module rtsr_front (
   input  logic [2:0]           req_opcode,
   input  logic                 req_line_level,
   input  logic [13:0]          req_year,
   input  logic [3:0]           req_month,
   input  logic [4:0]           req_day,
   input  logic [2:0]           req_day_of_week,
   input  logic [4:0]           req_hour,
   input  logic [5:0]           req_minute,
   input  logic [5:0]           req_second,
   output rtsr_pkg::rtsr_cmd_type cmd
);
   import rtsr_pkg::*;

   logic [26:0] year_prod;
   logic [7:0]  year_hund;
   logic [13:0] year_rem_full;

   // year / 100 via 5243 / 2^19, exact over the 14-bit range
   assign year_prod     = 27'(req_year) * 27'd5243;
   assign year_hund     = year_prod[26:19];
   assign year_rem_full = req_year - 14'(year_hund * 7'd100);

   always_comb begin
      case (req_opcode)
         OP_ENABLE:           cmd.kind = CMD_ENABLE;
         OP_CLOCK:            cmd.kind = CMD_CLOCK;
         OP_DATA_IN:          cmd.kind = CMD_DATA_IN;
         OP_TIME:             cmd.kind = CMD_TIME;
         OP_DIRECTION,
         OP_READ:             cmd.kind = CMD_NONE;  // no visible effect
         default:             cmd.kind = CMD_NONE;
      endcase
      cmd.level    = req_line_level;
      cmd.sec_bcd  = bcd_of({1'b0, req_second});
      cmd.min_bcd  = bcd_of({1'b0, req_minute});
      cmd.hour_bcd = bcd_of({2'b0, req_hour});
      cmd.day_bcd  = bcd_of({2'b0, req_day});
      cmd.mon_bcd  = bcd_of({3'b0, req_month});
      cmd.wd_code  = WEEKDAY_CODE[req_day_of_week];
      cmd.year_rem = year_rem_full[6:0];
   end

endmodule

// ===== hw/rtl/rtsr_queue.sv =====
`timescale 1ns / 1ps

module rtsr_queue #(
   parameter int DEPTH = rtsr_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rtsr_pkg::rtsr_cmd_type cmd_in,
   input  logic                   pop,
   output rtsr_pkg::rtsr_cmd_type cmd_out,
   output rtsr_pkg::rtsr_qstat_type status
);
   import rtsr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtsr_cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign cmd_out      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/rtsr_back.sv =====
`timescale 1ns / 1ps

module rtsr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  rtsr_pkg::rtsr_cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_data_out
);
   import rtsr_pkg::*;

   logic       enable_ff, enable_in;
   logic       clk_level_ff, clk_level_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [2:0] byte_index_ff, byte_index_in;
   logic [7:0] time_bytes_ff [TIME_BYTES];
   logic [7:0] time_bytes_in [TIME_BYTES];
   logic       rsp_valid_ff, rsp_valid_in;
   logic       data_out_ff, data_out_in;
   logic [7:0] year_bcd;
   logic [7:0] load_byte;

   assign year_bcd  = bcd_of(cmd.year_rem);
   assign load_byte = (byte_index_ff < 3'(TIME_BYTES)) ? time_bytes_ff[byte_index_ff] : 8'h00;
   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      enable_in     = enable_ff;
      clk_level_in  = clk_level_ff;
      shift_in      = shift_ff;
      bit_count_in  = bit_count_ff;
      byte_index_in = byte_index_ff;
      time_bytes_in = time_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      data_out_in   = data_out_ff;
      if (cmd_pop) begin
         case (cmd.kind)
            CMD_ENABLE: begin
               if (cmd.level && !enable_ff) begin
                  byte_index_in = '0;
                  bit_count_in  = BIT_COUNT_RELOAD;
               end
               enable_in = cmd.level;
            end
            CMD_CLOCK: begin
               // ignored entirely while disabled
               if (enable_ff) begin
                  if (!clk_level_ff && cmd.level) begin
                     if (bit_count_ff[3]) begin
                        shift_in     = load_byte;
                        bit_count_in = 4'd1;
                        if (byte_index_ff != BYTE_INDEX_MAX) begin
                           byte_index_in = byte_index_ff + 1'b1;
                        end
                     end else begin
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_count_in = bit_count_ff + 1'b1;
                     end
                  end
                  clk_level_in = cmd.level;
               end
            end
            CMD_DATA_IN: begin
               shift_in = {shift_ff[7:1], shift_ff[0] | cmd.level};
            end
            CMD_TIME: begin
               time_bytes_in[0] = cmd.sec_bcd;
               time_bytes_in[1] = cmd.min_bcd;
               time_bytes_in[2] = cmd.hour_bcd;
               time_bytes_in[3] = {cmd.day_bcd[3:0], 1'b0, cmd.wd_code};
               time_bytes_in[4] = {cmd.mon_bcd[3:0], cmd.day_bcd[7:4]};
               time_bytes_in[5] = {year_bcd[3:0], cmd.mon_bcd[7:4]};
               time_bytes_in[6] = {4'h0, year_bcd[7:4]};
            end
            CMD_NONE: begin
            end
            default: begin
            end
         endcase
         rsp_valid_in = 1'b1;
         data_out_in  = shift_in[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         clk_level_ff  <= 1'b0;
         shift_ff      <= '0;
         bit_count_ff  <= BIT_COUNT_RELOAD;
         byte_index_ff <= '0;
         time_bytes_ff <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         clk_level_ff  <= clk_level_in;
         shift_ff      <= shift_in;
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         time_bytes_ff <= time_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_out_ff <= data_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = data_out_ff;

endmodule

// ===== hw/rtl/rtc_serial_time_readout_unit.sv =====
`timescale 1ns / 1ps
// Serial time readout of a real-time clock.
// Request channel (req_*): one line event per transaction. req_opcode names
// the event (chip enable, clock line, direction line, data in, read, time
// update), req_line_level is the new line level or data bit, and the date
// and time fields are used by the time-update event only.
// Response channel (rsp_*): exactly one transaction per request, in order;
// rsp_data_out is the serial data line (bit 7 of the shift byte) after the
// event has been applied.
// With the queue empty, an accepted request is written to a queue entry, then
// applied by the back end, which registers rsp_valid once the response slot is
// free; throughput is one transaction per cycle while rsp_stall is low.
// A front end classifies events and converts the time fields to BCD; a
// small command queue decouples it from the back end, which owns the line
// state and the response register. req_stall is high only when the queue
// is full, so a stalled receiver fills the queue before backing up.
// Reset (synchronous): queue empty, no response pending, all line levels and
// time bytes zero, first clock rise after chip enable loads byte zero.
module rtc_serial_time_readout_unit #(
   parameter int QUEUE_DEPTH = rtsr_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic        req_line_level,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [2:0]  req_day_of_week,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_out
);
   import rtsr_pkg::*;

   rtsr_cmd_type   front_cmd;
   rtsr_cmd_type   back_cmd;
   rtsr_qstat_type q_status;
   logic           q_push;
   logic           q_pop;

   // classify and convert; no state of its own
   rtsr_front u_front (
      .req_opcode      (req_opcode),
      .req_line_level  (req_line_level),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_day_of_week (req_day_of_week),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_second      (req_second),
      .cmd             (front_cmd)
   );

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;

   rtsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (front_cmd),
      .pop     (q_pop),
      .cmd_out (back_cmd),
      .status  (q_status)
   );

   // applies one command per cycle whenever the response slot frees up
   rtsr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (!q_status.empty),
      .cmd          (back_cmd),
      .cmd_pop      (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out)
   );

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with nothing queued and the response slot free, an accepted transaction
   // passes the queue entry and then the response register, raising rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_status.empty && (!rsp_valid || !rsp_stall)) |=> ##1 rsp_valid)
      else $error("response missing two cycles after acceptance");

   // nothing queued, nothing accepted, nothing pending: no response appears
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && q_status.empty && !q_push) |=> !rsp_valid)
      else $error("response appeared without a request");

endmodule

// ===== tb/sv/rtc_serial_time_readout_unit_tb.sv =====
`timescale 1ns / 1ps

module rtc_serial_time_readout_unit_tb;
   import rtsr_pkg::*;

   // Opcodes with no defined event; the block must leave its state alone
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   // Weekday code stored for Sunday
   localparam logic [2:0] SUNDAY_CODE = 3'd7;
   // Number of useful random transactions to send after the directed part
   localparam int RANDOM_EVENTS = 800;
   // Cycles to watch for stray responses once everything has come back
   localparam int TAIL_CYCLES = 20;

   // One request transaction. typed/val carry an expectation written by
   // hand; when typed is clear the line model supplies it.
   typedef struct packed {
      logic [2:0]  op;
      logic        lvl;
      logic [13:0] yr;
      logic [3:0]  mo;
      logic [4:0]  dy;
      logic [2:0]  dw;
      logic [4:0]  hr;
      logic [5:0]  mi;
      logic [5:0]  se;
      logic        typed;
      logic        val;
   } line_vector_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_READ;
   logic        req_line_level = 1'b0;
   logic [13:0] req_year = '0;
   logic [3:0]  req_month = '0;
   logic [4:0]  req_day = '0;
   logic [2:0]  req_day_of_week = '0;
   logic [4:0]  req_hour = '0;
   logic [5:0]  req_minute = '0;
   logic [5:0]  req_second = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_data_out;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rtc_serial_time_readout_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_line_level  (req_line_level),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_day_of_week (req_day_of_week),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_second      (req_second),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out)
   );

   // ---------------------------------------------------------------------
   // Line model: serial interface state as the host would see it
   // ---------------------------------------------------------------------
   logic       en_lvl;
   logic       sclk_lvl;
   logic       dir_lvl;        // stored only, never drives the data line
   logic [7:0] shift_reg;
   logic [3:0] bits_shifted;   // > 7 means the next clock rise loads a byte
   logic [2:0] byte_ptr;       // parks at BYTE_INDEX_MAX, which reads zero
   logic [7:0] time_reg [TIME_BYTES];

   logic data_line_expected [$];   // data line level per pending response
   int   fail_count = 0;
   int   useful_events = 0;         // transactions that change or use state
   bit   no_idle = 1'b0;            // burst mode: sender never idles

   function automatic logic [7:0] two_digit_bcd(input int unsigned x);
      return 8'(((x / 10) << 4) | (x % 10));
   endfunction

   function automatic void clear_line_model();
      en_lvl       = 1'b0;
      sclk_lvl     = 1'b0;
      dir_lvl      = 1'b0;
      shift_reg    = '0;
      bits_shifted = BIT_COUNT_RELOAD;
      byte_ptr     = '0;
      for (int i = 0; i < TIME_BYTES; i++) time_reg[i] = '0;
   endfunction

   // Date/time digits as laid out in the seven readout bytes. Fields above
   // their range go through the same tens/units split and are cut to 8 bits.
   function automatic void pack_time_bytes(input line_vector_type v);
      logic [7:0] day_bcd;
      logic [7:0] mon_bcd;
      logic [2:0] wd;
      day_bcd = two_digit_bcd(v.dy);
      mon_bcd = two_digit_bcd(v.mo);
      wd = (v.dw == 3'd0) ? SUNDAY_CODE : v.dw;
      time_reg[0] = two_digit_bcd(v.se);
      time_reg[1] = two_digit_bcd(v.mi);
      time_reg[2] = two_digit_bcd(v.hr);
      time_reg[3] = {day_bcd[3:0], 1'b0, wd};
      time_reg[4] = {mon_bcd[3:0], day_bcd[7:4]};
      time_reg[5] = {4'(v.yr % 10), mon_bcd[7:4]};
      time_reg[6] = 8'((v.yr % 100) / 10);
   endfunction

   // Applies one line event and returns the data line level after it
   function automatic logic apply_line_event(input line_vector_type v);
      case (v.op)
         OP_ENABLE: begin
            // rising chip enable restarts the readout at byte zero
            if (v.lvl && !en_lvl) begin
               byte_ptr     = '0;
               bits_shifted = BIT_COUNT_RELOAD;
            end
            en_lvl = v.lvl;
         end
         OP_CLOCK: begin
            // disabled: event dropped, stored clock level kept
            if (en_lvl) begin
               if (!sclk_lvl && v.lvl) begin
                  if (bits_shifted > 4'd7) begin
                     bits_shifted = '0;
                     shift_reg = (byte_ptr < TIME_BYTES) ? time_reg[byte_ptr] : 8'h00;
                     if (byte_ptr < BYTE_INDEX_MAX) byte_ptr = byte_ptr + 3'd1;
                  end else begin
                     shift_reg = {shift_reg[6:0], 1'b0};
                  end
                  bits_shifted = bits_shifted + 4'd1;
               end
               sclk_lvl = v.lvl;
            end
         end
         OP_DIRECTION: dir_lvl = v.lvl;
         OP_DATA_IN:   shift_reg[0] = shift_reg[0] | v.lvl;
         OP_TIME:      pack_time_bytes(v);
         default: ;    // read and spare opcodes leave state alone
      endcase
      return shift_reg[7];
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Mostly back-to-back, sometimes a short pause, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Line event with don't-care time fields randomized so payload bits toggle
   function automatic line_vector_type line_event(input logic [2:0] op, input logic lvl);
      line_vector_type v;
      v.op    = op;
      v.lvl   = lvl;
      v.yr    = 14'($urandom);
      v.mo    = 4'($urandom);
      v.dy    = 5'($urandom);
      v.dw    = 3'($urandom);
      v.hr    = 5'($urandom);
      v.mi    = 6'($urandom);
      v.se    = 6'($urandom);
      v.typed = 1'b0;
      v.val   = 1'b0;
      return v;
   endfunction

   // Time update; wild allows any bit pattern, else a plausible calendar date
   function automatic line_vector_type time_event(input bit wild);
      line_vector_type v;
      v = line_event(OP_TIME, 1'($urandom));
      if (!wild) begin
         v.yr = 14'($urandom_range(0, 9999));
         v.mo = 4'($urandom_range(1, 12));
         v.dy = 5'($urandom_range(1, 31));
         v.dw = 3'($urandom_range(0, 6));
         v.hr = 5'($urandom_range(0, 23));
         v.mi = 6'($urandom_range(0, 59));
         v.se = 6'($urandom_range(0, 59));
      end
      return v;
   endfunction

   // One request transaction: optional idle gap, then hold valid and payload
   // until the block takes it. req_stall is sampled at the falling edge, so
   // the acceptance edge is the following rising edge.
   task automatic drive_event(input line_vector_type v);
      int   gap;
      logic predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= v.op;
      req_line_level  <= v.lvl;
      req_year        <= v.yr;
      req_month       <= v.mo;
      req_day         <= v.dy;
      req_day_of_week <= v.dw;
      req_hour        <= v.hr;
      req_minute      <= v.mi;
      req_second      <= v.se;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      if (!(v.op == OP_CLOCK && !en_lvl) && v.op != OP_READ && v.op <= OP_TIME)
         useful_events++;
      predicted = apply_line_event(v);
      data_line_expected.push_back(v.typed ? v.val : predicted);
   endtask

   // Sender holds off until every response is back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (data_line_expected.size() != 0);
   endtask

   // Well-formed readout: optional time update, enable rise, a run of clock
   // pulses with the odd stray event in between, then maybe enable low.
   // Long runs walk past the last time byte into the zero-reading index.
   task automatic readout_sequence();
      int rises;
      int r;
      if ($urandom_range(0, 3) != 0) drive_event(time_event($urandom_range(0, 5) == 0));
      drive_event(line_event(OP_ENABLE, 1'b0));
      drive_event(line_event(OP_ENABLE, 1'b1));
      r = $urandom_range(0, 9);
      rises = (r < 6) ? $urandom_range(1, 24) :
              (r < 9) ? $urandom_range(50, 72) : $urandom_range(0, 4);
      for (int i = 0; i < rises; i++) begin
         drive_event(line_event(OP_CLOCK, 1'b1));
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 6))
               0, 1: drive_event(line_event(OP_DATA_IN, 1'($urandom)));
               2:    drive_event(line_event(OP_READ, 1'($urandom)));
               3:    drive_event(line_event(OP_DIRECTION, 1'($urandom)));
               4:    drive_event(line_event($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                                            1'($urandom)));
               5:    drive_event(line_event(OP_CLOCK, 1'b1));   // no new edge
               default: begin
                  // restart mid-transfer
                  drive_event(line_event(OP_ENABLE, 1'b0));
                  drive_event(line_event(OP_ENABLE, 1'b1));
               end
            endcase
         end
         drive_event(line_event(OP_CLOCK, 1'b0));
      end
      if ($urandom_range(0, 1) != 0) drive_event(line_event(OP_ENABLE, 1'b0));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall bursts of mixed length, with stall-free stretches
   // ---------------------------------------------------------------------
   initial begin
      int r;
      forever begin
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20))
            @(posedge clock);
         r = $urandom_range(0, 99);
         rsp_stall <= 1'b1;
         repeat ((r < 70) ? $urandom_range(1, 3) :
                 (r < 92) ? $urandom_range(4, 10) : $urandom_range(20, 40))
            @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Response check: a transaction completes at the rising edge after a
   // falling edge with valid high and stall low; nothing moves in between.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (data_line_expected.size() == 0) begin
            note_failure($sformatf("%0t: response with none pending, data_out %0b",
                                   $time, rsp_data_out));
         end else if (rsp_data_out !== data_line_expected[0]) begin
            note_failure($sformatf("%0t: data_out expected %0b got %0b",
                                   $time, data_line_expected[0], rsp_data_out));
            void'(data_line_expected.pop_front());
         end else begin
            void'(data_line_expected.pop_front());
         end
      end
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[rtc_serial_time_readout_unit] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   line_vector_type directed_rows [23];
   bit drained_once = 1'b0;

   initial begin
      // op, lvl, year, month, day, weekday, hour, minute, second, typed, val
      directed_rows = '{
         '{OP_READ,      1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b1, 1'b0}, // out of reset
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b1, 1'b0}, // clock, disabled
         '{OP_DIRECTION, 1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b1, 1'b0},
         '{OP_DATA_IN,   1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b1, 1'b0}, // sets bit 0 only
         '{OP_TIME,      1'b1, 9999,  12, 31, 0, 23, 59, 59, 1'b1, 1'b0}, // Sunday, max date
         '{OP_ENABLE,    1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // loads seconds
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // level held
         '{OP_CLOCK,     1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // shift
         '{OP_DATA_IN,   1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_SPARE_A,   1'b1, 16383, 15, 31, 7, 31, 63, 63, 1'b0, 1'b0},
         '{OP_SPARE_B,   1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_TIME,      1'b0, 16383, 15, 31, 7, 31, 63, 63, 1'b0, 1'b0}, // over range
         '{OP_ENABLE,    1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_CLOCK,     1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // dropped
         '{OP_ENABLE,    1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // restart
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // still high
         '{OP_CLOCK,     1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_CLOCK,     1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // byte zero again
         '{OP_TIME,      1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}, // all zero
         '{OP_DIRECTION, 1'b0, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0},
         '{OP_READ,      1'b1, 0,     0,  0,  0, 0,  0,  0,  1'b0, 1'b0}
      };
      clear_line_model();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) drive_event(directed_rows[i]);

      // Random part: mostly readout sequences, some noise bursts with any
      // opcode and any field pattern.
      useful_events = 0;
      while (useful_events < RANDOM_EVENTS) begin
         no_idle = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12))
               drive_event(line_event(3'($urandom_range(0, 7)), 1'($urandom)));
         end else begin
            readout_sequence();
         end
         if ((!drained_once && useful_events > RANDOM_EVENTS / 3) ||
             $urandom_range(0, 19) == 0) begin
            wait_drain();
            drained_once = 1'b1;
         end
      end

      // Let the block empty out, then watch a little longer for strays
      req_valid <= 1'b0;
      do @(posedge clock); while (data_line_expected.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[rtc_serial_time_readout_unit] OK");
      else
         $display("[rtc_serial_time_readout_unit] ERROR");
      $finish;
   end

endmodule
